// ===== src/rgb_led_fade_controller_defines.svh =====
// Assertion macros shared by the LED fader RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef RGB_LED_FADE_CONTROLLER_DEFINES_SVH
`define RGB_LED_FADE_CONTROLLER_DEFINES_SVH

// Property must hold at every clock edge out of reset.
`define RGBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define RGBF_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== src/rgbf_pkg.sv =====
// Shared types, constants and helper functions for the LED fader.
// No dependencies.
package rgbf_pkg;

  localparam int unsigned OpW     = 3;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned SecW    = 8;
  localparam int unsigned FadeW   = 16;
  localparam int unsigned LfsrW   = 16;
  localparam int unsigned RotW    = 18;
  localparam int unsigned NumChan = 3;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [FadeW-1:0]  FadeIntervalReset = 16'd10;
  localparam logic [LfsrW-1:0]  RandomSeedReset   = 16'd44257;
  localparam logic [LfsrW-1:0]  LfsrMask          = 16'hB400;
  localparam logic [SecW-1:0]   RotMinSec         = 8'd5;
  localparam logic [RotW-1:0]   MsPerSec          = 18'd1000;
  localparam logic [RotW-1:0]   RotMax            = '1;
  localparam logic [FadeW-1:0]  FadeMax           = '1;
  localparam logic [LevelW-1:0] FullLevel         = 8'd255;

  typedef enum logic [OpW-1:0] {
    OP_TICK    = 3'd0,
    OP_OFF     = 3'd1,
    OP_ON      = 3'd2,
    OP_SET_RGB = 3'd3,
    OP_ROTATE  = 3'd4
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FADE_INTERVAL = 1'd0,
    CFG_RANDOM_SEED   = 1'd1
  } cfg_idx_e;

  // index 0 red, 1 green, 2 blue
  typedef logic [NumChan-1:0][LevelW-1:0] color_t;

  typedef struct packed {
    logic [OpW-1:0]    operation;
    logic [LevelW-1:0] red_in;
    logic [LevelW-1:0] green_in;
    logic [LevelW-1:0] blue_in;
    logic [SecW-1:0]   rotate_seconds;
  } item_t;

  typedef struct packed {
    logic [LevelW-1:0] red_level;
    logic [LevelW-1:0] green_level;
    logic [LevelW-1:0] blue_level;
    logic              levels_changed;
  } result_t;

  // One Galois step, shift right with feedback on the bit shifted out.
  function automatic logic [LfsrW-1:0] lfsr_next(input logic [LfsrW-1:0] v);
    logic [LfsrW-1:0] s;
    s = v >> 1;
    if (v[0]) s = s ^ LfsrMask;
    return s;
  endfunction

  // Random level in 128..255 from the low bits of the LFSR.
  function automatic logic [LevelW-1:0] lfsr_level(input logic [LfsrW-1:0] v);
    return {1'b1, v[LevelW-2:0]};
  endfunction

  // A zero seed would lock the LFSR up.
  function automatic logic [LfsrW-1:0] seed_fix(input logic [LfsrW-1:0] v);
    return (v == '0) ? LfsrW'(1) : v;
  endfunction

endpackage

// ===== src/rgbf_if.sv =====
// Valid/ready channel interfaces for the LED fader input and output words.
// Depends on rgbf_pkg.
interface rgbf_in_if;
  logic                        valid;
  logic                        ready;
  logic [rgbf_pkg::OpW-1:0]    operation;
  logic [rgbf_pkg::LevelW-1:0] red_in;
  logic [rgbf_pkg::LevelW-1:0] green_in;
  logic [rgbf_pkg::LevelW-1:0] blue_in;
  logic [rgbf_pkg::SecW-1:0]   rotate_seconds;

  modport source (output valid, operation, red_in, green_in, blue_in, rotate_seconds,
                  input ready);
  modport sink (input valid, operation, red_in, green_in, blue_in, rotate_seconds,
                output ready);
endinterface

interface rgbf_out_if;
  logic                        valid;
  logic                        ready;
  logic [rgbf_pkg::LevelW-1:0] red_level;
  logic [rgbf_pkg::LevelW-1:0] green_level;
  logic [rgbf_pkg::LevelW-1:0] blue_level;
  logic                        levels_changed;

  modport source (output valid, red_level, green_level, blue_level, levels_changed,
                  input ready);
  modport sink (input valid, red_level, green_level, blue_level, levels_changed,
                output ready);
endinterface

// ===== src/rgbf_out_buf.sv =====
// Two-entry output buffer (head register plus skid register) for result words.
// Depends on rgbf_pkg, rgbf_if and the assertion macro header.
`include "rgb_led_fade_controller_defines.svh"

module rgbf_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rgbf_pkg::result_t push_data_i,
  output logic              full_o,
  rgbf_out_if.source        out_o
);

  logic              head_vld_q, head_vld_d;
  logic              skid_vld_q, skid_vld_d;
  rgbf_pkg::result_t head_q, head_d;
  rgbf_pkg::result_t skid_q, skid_d;
  logic              pop;

  assign pop = head_vld_q && out_o.ready;

  always_comb begin
    head_vld_d = head_vld_q;
    skid_vld_d = skid_vld_q;
    head_d     = head_q;
    skid_d     = skid_q;
    if (pop) begin
      if (skid_vld_q) begin
        head_d     = skid_q;
        skid_vld_d = push_i;
        skid_d     = push_data_i;
      end else begin
        head_vld_d = push_i;
        head_d     = push_data_i;
      end
    end else if (push_i) begin
      if (!head_vld_q) begin
        head_vld_d = 1'b1;
        head_d     = push_data_i;
      end else begin
        skid_vld_d = 1'b1;
        skid_d     = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign full_o               = skid_vld_q;
  assign out_o.valid          = head_vld_q;
  assign out_o.red_level      = head_q.red_level;
  assign out_o.green_level    = head_q.green_level;
  assign out_o.blue_level     = head_q.blue_level;
  assign out_o.levels_changed = head_q.levels_changed;

  `RGBF_NEVER(a_no_overflow, push_i && skid_vld_q, "result pushed into full buffer")
  `RGBF_ASSERT(a_skid_behind_head, skid_vld_q |-> head_vld_q, "skid holds word without head")

endmodule

// ===== src/rgb_led_fade_controller.sv =====
// RGB LED fade controller: three-channel level fader with random color rotation.
// Result path: each word passes through the input register, then the result buffer, before its result is valid.
// Throughput: one word per cycle while the result buffer has room; the per-word update of all state is combinational.
// A two-entry result buffer lets input words keep flowing while a result waits.
// Reset (rst_ni, async active low): levels/targets/counters clear, fade_interval = 10,
// LFSR loads 44257. Depends on rgbf_pkg, rgbf_if, rgbf_out_buf and the macro header.
`include "rgb_led_fade_controller_defines.svh"

module rgb_led_fade_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rgbf_in_if.sink                         in_i,
  rgbf_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [rgbf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [rgbf_pkg::CfgDataW-1:0]   cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Input stage: one word register. It drains whenever the result buffer has
  // room, so ready only drops when both the input register and skid are full.
  // ---------------------------------------------------------------------------
  logic            item_vld_q, item_vld_d;
  rgbf_pkg::item_t item_q;
  logic            buf_full;
  logic            advance;
  logic            accept;

  assign advance    = item_vld_q && !buf_full;
  assign in_i.ready = !item_vld_q || !buf_full;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    item_vld_d = item_vld_q;
    if (accept)       item_vld_d = 1'b1;
    else if (advance) item_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.operation      <= in_i.operation;
      item_q.red_in         <= in_i.red_in;
      item_q.green_in       <= in_i.green_in;
      item_q.blue_in        <= in_i.blue_in;
      item_q.rotate_seconds <= in_i.rotate_seconds;
    end
  end

  // ---------------------------------------------------------------------------
  // Controller state
  // ---------------------------------------------------------------------------
  rgbf_pkg::color_t                cur_q, cur_d;
  rgbf_pkg::color_t                tgt_q, tgt_d;
  rgbf_pkg::color_t                rem_q, rem_d;
  logic                            rot_active_q, rot_active_d;
  logic [rgbf_pkg::RotW-1:0]       rot_period_q, rot_period_d;
  logic [rgbf_pkg::RotW-1:0]       rot_elapsed_q, rot_elapsed_d;
  logic [rgbf_pkg::FadeW-1:0]      fade_elapsed_q, fade_elapsed_d;
  logic [rgbf_pkg::LfsrW-1:0]      lfsr_q, lfsr_d;
  logic [rgbf_pkg::FadeW-1:0]      fade_interval_q, fade_interval_d;

  // Random draw: three chained LFSR steps, red first.
  logic [rgbf_pkg::LfsrW-1:0]      lfsr1, lfsr2, lfsr3;
  rgbf_pkg::color_t                draw_color;

  assign lfsr1 = rgbf_pkg::lfsr_next(lfsr_q);
  assign lfsr2 = rgbf_pkg::lfsr_next(lfsr1);
  assign lfsr3 = rgbf_pkg::lfsr_next(lfsr2);
  assign draw_color[0] = rgbf_pkg::lfsr_level(lfsr1);
  assign draw_color[1] = rgbf_pkg::lfsr_level(lfsr2);
  assign draw_color[2] = rgbf_pkg::lfsr_level(lfsr3);

  // Tick path: rotation is serviced first, fading then looks at the new target.
  logic [rgbf_pkg::RotW-1:0]       rot_inc;
  logic                            rot_fire;
  rgbf_pkg::color_t                tgt_tick;
  logic [rgbf_pkg::FadeW-1:0]      fade_inc;
  logic                            fade_fire;
  rgbf_pkg::color_t                stepped;

  assign rot_inc  = (rot_elapsed_q == rgbf_pkg::RotMax) ? rot_elapsed_q
                                                        : rot_elapsed_q + rgbf_pkg::RotW'(1);
  assign rot_fire = rot_active_q && (rot_inc > rot_period_q);
  assign tgt_tick = rot_fire ? draw_color : tgt_q;
  assign fade_inc = (fade_elapsed_q == rgbf_pkg::FadeMax) ? fade_elapsed_q
                                                          : fade_elapsed_q + rgbf_pkg::FadeW'(1);
  assign fade_fire = (cur_q != tgt_tick) && (fade_inc > fade_interval_q);

  // One level toward target on every channel, channels independent.
  always_comb begin
    for (int c = 0; c < rgbf_pkg::NumChan; c++) begin
      if (cur_q[c] < tgt_tick[c])      stepped[c] = cur_q[c] + rgbf_pkg::LevelW'(1);
      else if (cur_q[c] > tgt_tick[c]) stepped[c] = cur_q[c] - rgbf_pkg::LevelW'(1);
      else                             stepped[c] = cur_q[c];
    end
  end

  // Rotation period in ms: max(5, seconds) * 1000, at most 255000.
  logic [rgbf_pkg::SecW-1:0]       rot_secs;
  logic [rgbf_pkg::RotW-1:0]       rot_period_new;

  assign rot_secs = (item_q.rotate_seconds < rgbf_pkg::RotMinSec) ? rgbf_pkg::RotMinSec
                                                                  : item_q.rotate_seconds;
  assign rot_period_new = rgbf_pkg::RotW'(rot_secs) * rgbf_pkg::MsPerSec;

  logic                            changed;

  always_comb begin
    cur_d           = cur_q;
    tgt_d           = tgt_q;
    rem_d           = rem_q;
    rot_active_d    = rot_active_q;
    rot_period_d    = rot_period_q;
    rot_elapsed_d   = rot_elapsed_q;
    fade_elapsed_d  = fade_elapsed_q;
    lfsr_d          = lfsr_q;
    fade_interval_d = fade_interval_q;
    changed         = 1'b0;

    if (advance) begin
      case (item_q.operation)
        rgbf_pkg::OP_TICK: begin
          if (rot_active_q) begin
            rot_elapsed_d = rot_fire ? '0 : rot_inc;
          end
          if (rot_fire) begin
            lfsr_d = lfsr3;
          end
          tgt_d          = tgt_tick;
          fade_elapsed_d = fade_fire ? '0 : fade_inc;
          if (fade_fire) begin
            cur_d   = stepped;
            changed = 1'b1;
          end
        end
        rgbf_pkg::OP_OFF: begin
          rot_active_d = 1'b0;
          tgt_d        = '0;
        end
        rgbf_pkg::OP_ON: begin
          rot_active_d = 1'b0;
          // all-dark memory means full white
          if (rem_q == '0) begin
            rem_d = {rgbf_pkg::NumChan{rgbf_pkg::FullLevel}};
            tgt_d = {rgbf_pkg::NumChan{rgbf_pkg::FullLevel}};
          end else begin
            tgt_d = rem_q;
          end
        end
        rgbf_pkg::OP_SET_RGB: begin
          rot_active_d = 1'b0;
          rem_d[0]     = item_q.red_in;
          rem_d[1]     = item_q.green_in;
          rem_d[2]     = item_q.blue_in;
          tgt_d[0]     = item_q.red_in;
          tgt_d[1]     = item_q.green_in;
          tgt_d[2]     = item_q.blue_in;
        end
        rgbf_pkg::OP_ROTATE: begin
          rot_period_d  = rot_period_new;
          rot_active_d  = 1'b1;
          rot_elapsed_d = '0;
          tgt_d         = draw_color;
          lfsr_d        = lfsr3;
        end
        default: begin
          // unused codes leave state alone
        end
      endcase
    end

    // Config writes are to arrive only while idle; the block itself does not enforce this.
    if (cfg_we_i) begin
      case (cfg_index_i)
        rgbf_pkg::CFG_FADE_INTERVAL: fade_interval_d = cfg_data_i;
        rgbf_pkg::CFG_RANDOM_SEED:   lfsr_d          = rgbf_pkg::seed_fix(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q      <= 1'b0;
      cur_q           <= '0;
      tgt_q           <= '0;
      rem_q           <= '0;
      rot_active_q    <= 1'b0;
      rot_period_q    <= '0;
      rot_elapsed_q   <= '0;
      fade_elapsed_q  <= '0;
      lfsr_q          <= rgbf_pkg::seed_fix(rgbf_pkg::RandomSeedReset);
      fade_interval_q <= rgbf_pkg::FadeIntervalReset;
    end else begin
      item_vld_q      <= item_vld_d;
      cur_q           <= cur_d;
      tgt_q           <= tgt_d;
      rem_q           <= rem_d;
      rot_active_q    <= rot_active_d;
      rot_period_q    <= rot_period_d;
      rot_elapsed_q   <= rot_elapsed_d;
      fade_elapsed_q  <= fade_elapsed_d;
      lfsr_q          <= lfsr_d;
      fade_interval_q <= fade_interval_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result word: levels after the update plus the fade-step flag.
  // ---------------------------------------------------------------------------
  rgbf_pkg::result_t result;

  assign result.red_level      = cur_d[0];
  assign result.green_level    = cur_d[1];
  assign result.blue_level     = cur_d[2];
  assign result.levels_changed = changed;

  rgbf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance),
    .push_data_i (result),
    .full_o      (buf_full),
    .out_o       (out_o)
  );

  `RGBF_NEVER(a_lfsr_nonzero, lfsr_q == '0, "LFSR locked at zero")
  `RGBF_ASSERT(a_rot_elapsed_bound, rot_active_q |-> (rot_elapsed_q <= rot_period_q),
               "rotation counter beyond period")
  `RGBF_ASSERT(a_rot_target_bright,
               rot_active_q |-> (tgt_q[0][7] && tgt_q[1][7] && tgt_q[2][7]),
               "rotation target below half level")
  `RGBF_ASSERT(a_cmd_keeps_levels,
               (advance && (item_q.operation != rgbf_pkg::OP_TICK)) |=> $stable(cur_q),
               "command changed drive levels")

endmodule
